/* design/iol_pkg.sv */
// Package: shared constants, codes and interface structs of the ordered list unit
`timescale 1ns / 1ps
package iol_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 6;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 7;

   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (POS_W > COUNT_W) ? POS_W : COUNT_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_GET        = 3'd0,
      CMD_INS_HEAD   = 3'd1,
      CMD_INS_TAIL   = 3'd2,
      CMD_INS_BEFORE = 3'd3,
      CMD_DELETE     = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GET_WAIT,
      S_SHIFT_UP,
      S_INS_WR,
      S_SHIFT_DN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_W-1:0]     wr_addr;
      logic [DATA_WIDTH-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_W-1:0]     rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic                       valid;
      status_type                 status;
      logic signed [VALUE_W-1:0]  read_value;
      logic [LENGTH_W-1:0]        length;
   } result_type;

endpackage

/* design/indexed_ordered_list_unit.sv */
// Top level: ordered list of signed values kept in one RAM, with indexed insert and delete
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  req_      in         req_valid / req_stall     command, position, value
//  rsp_      out        rsp_valid / rsp_stall     status, read_value, length
//
//  One command is in work at a time; the element RAM has one read and one write
//  port, so an insert or delete moves one element per cycle.
//  A result is held in the output register until taken; the next command
//  is accepted while it waits. Reset clears the element count, the sequencer
//  state and the output valid flag; no RAM sweep.
module indexed_ordered_list_unit import iol_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_W-1:0]          req_command,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_read_value,
   output logic [LENGTH_W-1:0]       rsp_length
);

   mem_req_type           mem_req;
   logic [DATA_WIDTH-1:0] mem_rd_data;
   result_type            res;
   logic                  res_free;

   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic signed [VALUE_W-1:0] rsp_read_value_ff;
   logic [LENGTH_W-1:0]       rsp_length_ff;

   // element store: one entry per list slot, entries 0 .. count-1 in order
   iol_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   iol_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_position (req_position),
      .req_value    (req_value),
      .mem_req      (mem_req),
      .mem_rd_data  (mem_rd_data),
      .res_free     (res_free),
      .res          (res)
   );

   // output register is free when empty or when its transfer completes now
   assign res_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid && res_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold payload while stalled; load a new result only when free
   always_ff @(posedge clock) begin
      if (res.valid && res_free) begin
         rsp_status_ff     <= res.status;
         rsp_read_value_ff <= res.read_value;
         rsp_length_ff     <= res.length;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_length     = rsp_length_ff;

endmodule

/* design/iol_ram.sv */
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
module iol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/iol_seq.sv */
// Sequencer: command decode, element count and shift walks over the element RAM
`timescale 1ns / 1ps
module iol_seq import iol_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [VALUE_W-1:0] req_value,
   output mem_req_type              mem_req,
   input  logic [DATA_WIDTH-1:0]    mem_rd_data,
   input  logic                     res_free,
   output result_type               res
);

   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]         ptr_ff, ptr_in;
   logic [ADDR_W-1:0]         pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]     value_ff, value_in;
   status_type                status_ff, status_in;
   logic signed [VALUE_W-1:0] rdval_ff, rdval_in;

   logic [CMP_W-1:0]  pos_c;
   logic [CMP_W-1:0]  cnt_c;
   logic [CMP_W-1:0]  ins_c;
   logic [ADDR_W-1:0] last_addr;

   assign pos_c     = CMP_W'(req_position);
   assign cnt_c     = CMP_W'(count_ff);
   assign last_addr = ADDR_W'(count_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      value_in  = value_ff;
      status_in = status_ff;
      rdval_in  = rdval_ff;
      mem_req   = '0;
      ins_c     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in  = DATA_WIDTH'(req_value);
               status_in = ST_RANGE;
               rdval_in  = '1;
               state_in  = S_RESP;
               case (cmd_type'(req_command))
                  CMD_GET: begin
                     if (pos_c < cnt_c) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ADDR_W'(req_position);
                        state_in        = S_GET_WAIT;
                     end
                  end
                  CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_BEFORE: begin
                     if (cmd_type'(req_command) == CMD_INS_HEAD) begin
                        ins_c = '0;
                     end else if (cmd_type'(req_command) == CMD_INS_TAIL) begin
                        ins_c = cnt_c;
                     end else begin
                        ins_c = pos_c;
                     end
                     if (ins_c > cnt_c) begin
                        status_in = ST_RANGE;
                     end else if (count_ff == COUNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else if (ins_c == cnt_c) begin
                        // append: nothing to move
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ADDR_W'(ins_c);
                        mem_req.wr_data = DATA_WIDTH'(req_value);
                        count_in        = count_ff + 1'b1;
                        status_in       = ST_DONE;
                     end else begin
                        pos_in          = ADDR_W'(ins_c);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = last_addr;
                        ptr_in          = last_addr;
                        state_in        = S_SHIFT_UP;
                     end
                  end
                  CMD_DELETE: begin
                     if (pos_c < cnt_c) begin
                        if (pos_c == cnt_c - 1'b1) begin
                           // last element: drop it by count alone
                           count_in  = count_ff - 1'b1;
                           status_in = ST_DONE;
                        end else begin
                           mem_req.rd_en   = 1'b1;
                           mem_req.rd_addr = ADDR_W'(req_position) + 1'b1;
                           ptr_in          = ADDR_W'(req_position) + 1'b1;
                           state_in        = S_SHIFT_DN;
                        end
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_GET_WAIT: begin
            rdval_in  = VALUE_W'(signed'(mem_rd_data));
            status_in = ST_DONE;
            state_in  = S_RESP;
         end
         S_SHIFT_UP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_ff + 1'b1;
            mem_req.wr_data = mem_rd_data;
            if (ptr_ff == pos_ff) begin
               state_in = S_INS_WR;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptr_ff - 1'b1;
               ptr_in          = ptr_ff - 1'b1;
            end
         end
         S_INS_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            mem_req.wr_data = value_ff;
            count_in        = count_ff + 1'b1;
            status_in       = ST_DONE;
            state_in        = S_RESP;
         end
         S_SHIFT_DN: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_ff - 1'b1;
            mem_req.wr_data = mem_rd_data;
            if (ptr_ff == last_addr) begin
               count_in  = count_ff - 1'b1;
               status_in = ST_DONE;
               state_in  = S_RESP;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptr_ff + 1'b1;
               ptr_in          = ptr_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (res_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign res.valid      = (state_ff == S_RESP);
   assign res.status     = status_ff;
   assign res.read_value = rdval_ff;
   assign res.length     = LENGTH_W'(count_ff);

endmodule
